FILE: design/wrmse_pkg.sv
// wrmse_pkg: shared types and constants for the weighted rmse block
// holds the controller/datapath command and status structs and job codes
// no dependencies
package wrmse_pkg;

  localparam int RES_W  = 16;
  localparam int QUOT_W = 2 * RES_W;

  typedef logic [1:0] job_t;

  localparam job_t JOB_CH0 = 2'd0;
  localparam job_t JOB_CH1 = 2'd1;
  localparam job_t JOB_CH2 = 2'd2;
  localparam job_t JOB_ALL = 2'd3;

  typedef struct packed {
    logic acc_clear;
    logic check;
    logic div_start;
    logic sqrt_start;
    logic res_wr;
    logic out_load;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic wsum_zero;
    logic div_done;
    logic sqrt_done;
    logic out_full;
  } status_t;

endpackage

FILE: design/wrmse_div.sv
// wrmse_div: iterative restoring divider, one quotient bit per cycle
// computes floor((num << SHIFT) / den), low QUOT_W bits plus overflow flag
// depends on wrmse_pkg
module wrmse_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 42,
  parameter int SHIFT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NUM_W-1:0]            num_i,
  input  logic [DEN_W-1:0]            den_i,
  output logic                        done_o,
  output logic [wrmse_pkg::QUOT_W-1:0] quot_o,
  output logic                        ovf_o
);
  import wrmse_pkg::*;

  localparam int DVD_W = NUM_W + SHIFT;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= DVD_W'(num_i) << SHIFT;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= rem_d;
      quot_q <= {quot_q[QUOT_W-2:0], fits};
      ovf_q  <= ovf_q | quot_q[QUOT_W-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

FILE: design/wrmse_sqrt.sv
// wrmse_sqrt: iterative integer square root, one result bit per cycle
// takes a QUOT_W-bit radicand and returns its RES_W-bit floor root
// depends on wrmse_pkg
module wrmse_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wrmse_pkg::QUOT_W-1:0] rad_i,
  output logic                         done_o,
  output logic [wrmse_pkg::RES_W-1:0]  root_o
);
  import wrmse_pkg::*;

  localparam int CNT_W = $clog2(RES_W + 1);

  logic [QUOT_W-1:0] rad_q;
  logic [RES_W:0]    rem_q;
  logic [RES_W-1:0]  root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [RES_W+2:0]  tmp;
  logic [RES_W+2:0]  trial;
  logic [RES_W+2:0]  diff;
  logic              ge;

  always_comb begin
    tmp   = {rem_q, rad_q[QUOT_W-1 -: 2]};
    trial = (RES_W+3)'({root_q, 2'b01});
    diff  = tmp - trial;
    ge    = tmp >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RES_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[RES_W:0] : tmp[RES_W:0];
      root_q <= {root_q[RES_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: design/wrmse_dp.sv
// wrmse_dp: datapath with square/weight pipeline, saturating accumulators,
// shared divider and square root, result and output word registers
// depends on wrmse_pkg, wrmse_div and wrmse_sqrt
module wrmse_dp #(
  parameter int SAMPLE_BITS = 8,
  parameter int WEIGHT_BITS = 16,
  parameter int PIXELS_LOG2 = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_accept_i,
  input  logic [SAMPLE_BITS-1:0]      a_ch0_i,
  input  logic [SAMPLE_BITS-1:0]      a_ch1_i,
  input  logic [SAMPLE_BITS-1:0]      a_ch2_i,
  input  logic [SAMPLE_BITS-1:0]      b_ch0_i,
  input  logic [SAMPLE_BITS-1:0]      b_ch1_i,
  input  logic [SAMPLE_BITS-1:0]      b_ch2_i,
  input  logic [WEIGHT_BITS-1:0]      weight_i,
  input  logic                        last_pixel_i,
  input  wrmse_pkg::cmd_t             cmd_i,
  output wrmse_pkg::status_t          status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_all_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_ch0_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_ch1_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_ch2_o,
  output logic                        zero_weight_o
);
  import wrmse_pkg::*;

  localparam int NCH      = 3;
  localparam int SQ_W     = 2 * SAMPLE_BITS;
  localparam int PROD_W   = SQ_W + WEIGHT_BITS;
  localparam int SSE_FULL = PROD_W + PIXELS_LOG2;
  localparam int SSE_W    = (SSE_FULL > 62) ? 62 : SSE_FULL;
  localparam int WS_FULL  = WEIGHT_BITS + PIXELS_LOG2;
  localparam int WS_W     = (WS_FULL > 61) ? 61 : WS_FULL;
  localparam int NUM_W    = SSE_W + 2;
  localparam int DEN_W    = WS_W + 2;
  localparam int SHIFT    = 2 * FRAC_BITS;

  logic [SAMPLE_BITS-1:0] a [NCH];
  logic [SAMPLE_BITS-1:0] b [NCH];
  logic [SAMPLE_BITS-1:0] dif [NCH];

  logic                   v1_q, last1_q;
  logic [SQ_W-1:0]        sq1_q [NCH];
  logic [WEIGHT_BITS-1:0] w1_q;
  logic                   v2_q, last2_q;
  logic [PROD_W-1:0]      prod2_q [NCH];
  logic [WEIGHT_BITS-1:0] w2_q;

  logic [SSE_W-1:0]       sse_q [NCH];
  logic [SSE_W-1:0]       sse_d [NCH];
  logic [SSE_W:0]         sse_sum [NCH];
  logic [WS_W-1:0]        wsum_q, wsum_d;
  logic [WS_W:0]          wsum_sum;
  logic [NUM_W-1:0]       tot_q;
  logic [DEN_W-1:0]       den3_q;

  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done, div_ovf;
  logic [QUOT_W-1:0]      quot;
  logic                   sqrt_done;
  logic [RES_W-1:0]       root;

  logic [RES_W-1:0]       res_q [4];
  logic                   zero_q;
  logic                   out_valid_q;
  logic [RES_W-1:0]       out_all_q, out_ch0_q, out_ch1_q, out_ch2_q;
  logic                   out_zero_q;

  assign a[0] = a_ch0_i;
  assign a[1] = a_ch1_i;
  assign a[2] = a_ch2_i;
  assign b[0] = b_ch0_i;
  assign b[1] = b_ch1_i;
  assign b[2] = b_ch2_i;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      dif[c]     = (a[c] > b[c]) ? (a[c] - b[c]) : (b[c] - a[c]);
      sse_sum[c] = {1'b0, sse_q[c]} + (SSE_W+1)'(prod2_q[c]);
      sse_d[c]   = sse_sum[c][SSE_W] ? '1 : sse_sum[c][SSE_W-1:0];
    end
    wsum_sum = {1'b0, wsum_q} + (WS_W+1)'(w2_q);
    wsum_d   = wsum_sum[WS_W] ? '1 : wsum_sum[WS_W-1:0];
  end

  // pixel pipeline: square, weight, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v1_q    <= in_accept_i;
      v2_q    <= v1_q;
      last1_q <= in_accept_i & last_pixel_i;
      last2_q <= v1_q & last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      for (int c = 0; c < NCH; c++) begin
        sq1_q[c] <= SQ_W'(dif[c]) * SQ_W'(dif[c]);
      end
      w1_q <= weight_i;
    end
    if (v1_q) begin
      for (int c = 0; c < NCH; c++) begin
        prod2_q[c] <= PROD_W'(sq1_q[c]) * PROD_W'(w1_q);
      end
      w2_q <= w1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        sse_q[c] <= '0;
      end
      wsum_q <= '0;
    end else if (cmd_i.acc_clear) begin
      for (int c = 0; c < NCH; c++) begin
        sse_q[c] <= '0;
      end
      wsum_q <= '0;
    end else if (v2_q) begin
      for (int c = 0; c < NCH; c++) begin
        sse_q[c] <= sse_d[c];
      end
      wsum_q <= wsum_d;
    end
  end

  // ensemble numerator and denominator
  always_ff @(posedge clk_i) begin
    tot_q  <= NUM_W'(sse_q[0]) + NUM_W'(sse_q[1]) + NUM_W'(sse_q[2]);
    den3_q <= DEN_W'(wsum_q) + (DEN_W'(wsum_q) << 1);
  end

  always_comb begin
    div_den = DEN_W'(wsum_q);
    case (cmd_i.job)
      JOB_CH0: div_num = NUM_W'(sse_q[0]);
      JOB_CH1: div_num = NUM_W'(sse_q[1]);
      JOB_CH2: div_num = NUM_W'(sse_q[2]);
      JOB_ALL: begin
        div_num = tot_q;
        div_den = den3_q;
      end
      default: div_num = '0;
    endcase
  end

  wrmse_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SHIFT (SHIFT)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot),
    .ovf_o   (div_ovf)
  );

  wrmse_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // per-job results, saturated when the quotient overflows, cleared at the check when the weight sum is zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      zero_q <= (wsum_q == '0);
      if (wsum_q == '0) begin
        for (int j = 0; j < 4; j++) begin
          res_q[j] <= '0;
        end
      end
    end else if (cmd_i.res_wr) begin
      res_q[cmd_i.job] <= div_ovf ? '1 : root;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ch0_q  <= res_q[JOB_CH0];
      out_ch1_q  <= res_q[JOB_CH1];
      out_ch2_q  <= res_q[JOB_CH2];
      out_all_q  <= res_q[JOB_ALL];
      out_zero_q <= zero_q;
    end
  end

  assign status_o.last_acc  = v2_q & last2_q;
  assign status_o.wsum_zero = (wsum_q == '0);
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.out_full  = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign rmse_all_o    = out_all_q;
  assign rmse_ch0_o    = out_ch0_q;
  assign rmse_ch1_o    = out_ch1_q;
  assign rmse_ch2_o    = out_ch2_q;
  assign zero_weight_o = out_zero_q;

endmodule

FILE: design/wrmse_ctrl.sv
// wrmse_ctrl: controller state machine for the weighted rmse block
// sequences accumulation, the four divide/root jobs (skipped when the weight sum is zero) and the output load
// depends on wrmse_pkg
module wrmse_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_accept_i,
  input  logic               last_pixel_i,
  input  wrmse_pkg::status_t status_i,
  output wrmse_pkg::cmd_t    cmd_o,
  output logic               in_ready_o
);
  import wrmse_pkg::*;

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_WAIT  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  logic [2:0] state_q, state_d;
  job_t       job_q, job_d;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    cmd_o   = '0;
    cmd_o.job = job_q;
    case (state_q)
      S_ACC: begin
        if (in_accept_i && last_pixel_i) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status_i.last_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        job_d       = JOB_CH0;
        state_d     = status_i.wsum_zero ? S_HOLD : S_START;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SQRT;
        end
      end
      S_SQRT: begin
        if (status_i.sqrt_done) begin
          cmd_o.res_wr = 1'b1;
          if (job_q == JOB_ALL) begin
            state_d = S_HOLD;
          end else begin
            job_d   = job_q + job_t'(1);
            state_d = S_START;
          end
        end
      end
      S_HOLD: begin
        if (!status_i.out_full) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.acc_clear = 1'b1;
          state_d         = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      job_q   <= JOB_CH0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  assign in_ready_o = (state_q == S_ACC);

endmodule

FILE: design/weighted_rmse_three_channel.sv
// weighted_rmse_three_channel: weighted rmse over a three-channel pixel stream
// pixels are taken one per cycle while in_ready_o is high and pass the square and
// weight registers before the accumulators; after a last pixel with a non-zero
// weight sum the four jobs use the shared bit-serial divider and 16-step square root
// input is stalled from the last pixel until the result enters the output register
// reset clears accumulators, pipeline valids, the controller and the output valid flag
module weighted_rmse_three_channel #(
  parameter int SAMPLE_BITS = 8,
  parameter int WEIGHT_BITS = 16,
  parameter int PIXELS_LOG2 = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [SAMPLE_BITS-1:0]      a_ch0_i,
  input  logic [SAMPLE_BITS-1:0]      a_ch1_i,
  input  logic [SAMPLE_BITS-1:0]      a_ch2_i,
  input  logic [SAMPLE_BITS-1:0]      b_ch0_i,
  input  logic [SAMPLE_BITS-1:0]      b_ch1_i,
  input  logic [SAMPLE_BITS-1:0]      b_ch2_i,
  input  logic [WEIGHT_BITS-1:0]      weight_i,
  input  logic                        last_pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wrmse_pkg::RES_W-1:0] rmse_all_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_ch0_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_ch1_o,
  output logic [wrmse_pkg::RES_W-1:0] rmse_ch2_o,
  output logic                        zero_weight_o
);
  import wrmse_pkg::*;

  logic    in_accept;
  cmd_t    cmd;
  status_t status;

  assign in_accept = in_valid_i & in_ready_o;

  wrmse_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .last_pixel_i (last_pixel_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .in_ready_o   (in_ready_o)
  );

  wrmse_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .PIXELS_LOG2 (PIXELS_LOG2),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_accept_i   (in_accept),
    .a_ch0_i       (a_ch0_i),
    .a_ch1_i       (a_ch1_i),
    .a_ch2_i       (a_ch2_i),
    .b_ch0_i       (b_ch0_i),
    .b_ch1_i       (b_ch1_i),
    .b_ch2_i       (b_ch2_i),
    .weight_i      (weight_i),
    .last_pixel_i  (last_pixel_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .rmse_all_o    (rmse_all_o),
    .rmse_ch0_o    (rmse_ch0_o),
    .rmse_ch1_o    (rmse_ch1_o),
    .rmse_ch2_o    (rmse_ch2_o),
    .zero_weight_o (zero_weight_o)
  );

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_pixel_i |=> !in_ready_o)
    else $error("input not stalled after last pixel");

  a_zero_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_weight_o |->
      rmse_all_o == '0 && rmse_ch0_o == '0 && rmse_ch1_o == '0 && rmse_ch2_o == '0)
    else $error("non-zero rmse with zero weight sum");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !status.out_full)
    else $error("output word overwritten");

  a_div_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !in_ready_o && !status.wsum_zero)
    else $error("divide started while accumulating or with zero weight");

endmodule
